>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Item formats, page metadata word, datapath commands and controller states.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ORD_W  = 4;
  localparam int PAGE_W = 10;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic              op;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_index_res;
    logic [1:0]        status;
  } rsp_t;

  // Per-page metadata: block start, allocated, block order.
  typedef struct packed {
    logic             head;
    logic             used;
    logic [ORD_W-1:0] ord;
  } meta_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT,
    DP_SCAN,
    DP_UNLINK_HEAD,
    DP_SPLIT,
    DP_ALLOC_FIN,
    DP_RD_PG,
    DP_BUD,
    DP_RD_HALF,
    DP_RD_LINKS,
    DP_UNLINK_B,
    DP_PUSH1,
    DP_PUSH2
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       respond;
    logic [1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic ord_big;
    logic is_free;
    logic pg_oob;
    logic found;
    logic lvl_top;
    logic lvl_eq_ord;
    logic pg_ok;
    logic run_end;
    logic bud_ok;
    logic lvl_zero;
    logic half_head;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_A_SCAN,
    S_A_UNLINK,
    S_A_SPLIT,
    S_F_CHKPG,
    S_F_BUD,
    S_F_CHKBUD,
    S_F_CHKHALF,
    S_F_UNLINK,
    S_F_PUSH1,
    S_F_PUSH2
  } state_t;

  function automatic meta_t mk_meta(input logic head, input logic used,
                                    input logic [ORD_W-1:0] ord);
    meta_t m;
    m.head = head;
    m.used = used;
    m.ord  = ord;
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output      logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl: sequencer of the buddy page allocator
// Steps the datapath through carving, allocation search/split and free merge.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire bpa_pkg::dp_stat_t  stat,
  output      bpa_pkg::dp_cmd_t   cmd
);
  bpa_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != bpa_pkg::S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cmd.op      = bpa_pkg::DP_NOP;
    cmd.respond = 1'b0;
    cmd.code    = bpa_pkg::ST_OK;
    unique case (state)
      bpa_pkg::S_INIT: begin
        cmd.op = bpa_pkg::DP_INIT;
        if (stat.init_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = bpa_pkg::DP_LOAD;
          state_next = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        if (stat.ord_big) begin
          cmd.respond = 1'b1;
          cmd.code    = bpa_pkg::ST_ORDER;
          state_next  = bpa_pkg::S_IDLE;
        end else if (!stat.is_free) begin
          state_next = bpa_pkg::S_A_SCAN;
        end else if (stat.pg_oob) begin
          cmd.respond = 1'b1;
          cmd.code    = bpa_pkg::ST_BADFREE;
          state_next  = bpa_pkg::S_IDLE;
        end else begin
          cmd.op     = bpa_pkg::DP_RD_PG;
          state_next = bpa_pkg::S_F_CHKPG;
        end
      end
      bpa_pkg::S_A_SCAN: begin
        cmd.op = bpa_pkg::DP_SCAN;
        if (stat.found) begin
          state_next = bpa_pkg::S_A_UNLINK;
        end else if (stat.lvl_top) begin
          cmd.respond = 1'b1;
          cmd.code    = bpa_pkg::ST_NOFREE;
          state_next  = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_A_UNLINK: begin
        cmd.op     = bpa_pkg::DP_UNLINK_HEAD;
        state_next = bpa_pkg::S_A_SPLIT;
      end
      bpa_pkg::S_A_SPLIT: begin
        if (stat.lvl_eq_ord) begin
          cmd.op      = bpa_pkg::DP_ALLOC_FIN;
          cmd.respond = 1'b1;
          state_next  = bpa_pkg::S_IDLE;
        end else begin
          cmd.op = bpa_pkg::DP_SPLIT;
        end
      end
      bpa_pkg::S_F_CHKPG: begin
        if (stat.pg_ok) begin
          state_next = bpa_pkg::S_F_BUD;
        end else begin
          cmd.respond = 1'b1;
          cmd.code    = bpa_pkg::ST_BADFREE;
          state_next  = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_F_BUD: begin
        if (stat.lvl_top || stat.run_end) begin
          state_next = bpa_pkg::S_F_PUSH1;
        end else begin
          cmd.op     = bpa_pkg::DP_BUD;
          state_next = bpa_pkg::S_F_CHKBUD;
        end
      end
      bpa_pkg::S_F_CHKBUD: begin
        if (!stat.bud_ok) begin
          state_next = bpa_pkg::S_F_PUSH1;
        end else if (stat.lvl_zero) begin
          cmd.op     = bpa_pkg::DP_RD_LINKS;
          state_next = bpa_pkg::S_F_UNLINK;
        end else begin
          cmd.op     = bpa_pkg::DP_RD_HALF;
          state_next = bpa_pkg::S_F_CHKHALF;
        end
      end
      bpa_pkg::S_F_CHKHALF: begin
        if (stat.half_head) begin
          state_next = bpa_pkg::S_F_PUSH1;
        end else begin
          cmd.op     = bpa_pkg::DP_RD_LINKS;
          state_next = bpa_pkg::S_F_UNLINK;
        end
      end
      bpa_pkg::S_F_UNLINK: begin
        cmd.op     = bpa_pkg::DP_UNLINK_B;
        state_next = bpa_pkg::S_F_BUD;
      end
      bpa_pkg::S_F_PUSH1: begin
        cmd.op     = bpa_pkg::DP_PUSH1;
        state_next = bpa_pkg::S_F_PUSH2;
      end
      bpa_pkg::S_F_PUSH2: begin
        cmd.op      = bpa_pkg::DP_PUSH2;
        cmd.respond = 1'b1;
        state_next  = bpa_pkg::S_IDLE;
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/bpa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_dpath: datapath of the buddy page allocator
// Page metadata and free-list link memories, list heads, working registers.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int NUM_PAGES = 1024,
  parameter int TOP_ORDER = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bpa_pkg::req_t      req,
  input  wire bpa_pkg::dp_cmd_t   cmd,
  output      bpa_pkg::dp_stat_t  stat,
  output      bpa_pkg::rsp_t      rsp,
  output      logic               done
);
  localparam int AW  = $clog2(NUM_PAGES + 1);
  localparam int IW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CWB = (AW > TOP_ORDER + 2) ? AW : TOP_ORDER + 2;
  localparam int CW  = CWB + 1;
  localparam int LVW = (TOP_ORDER > 0) ? $clog2(TOP_ORDER + 1) : 1;
  localparam int MW  = $bits(bpa_pkg::meta_t);

  localparam logic [AW-1:0]  NIL      = AW'(NUM_PAGES);
  localparam logic [CW-1:0]  NUM_C    = CW'(NUM_PAGES);
  localparam logic [CW-1:0]  TOP_SIZE = CW'(1) << TOP_ORDER;
  localparam logic [LVW-1:0] TOP_LVL  = LVW'(TOP_ORDER);

  // Highest set bit of a value (used when below the top block size).
  function automatic logic [LVW-1:0] msb_of(input logic [CW-1:0] v);
    logic [LVW-1:0] r;
    r = '0;
    for (int k = 0; k < CW; k++) begin
      if (v[k]) r = LVW'(k);
    end
    return r;
  endfunction

  // Working registers.
  bpa_pkg::req_t  req_q;
  logic [AW-1:0]  p;
  logic [LVW-1:0] lvl;
  logic [AW-1:0]  b;
  logic [AW-1:0]  fl;
  logic [AW-1:0]  init_i;
  logic [CW-1:0]  next_start;
  logic [AW-1:0]  list_first [0:TOP_ORDER];

  // Memory ports.
  logic           meta_we, next_we, prev_we;
  logic [IW-1:0]  meta_waddr, next_waddr, prev_waddr;
  logic [IW-1:0]  meta_raddr, next_raddr, prev_raddr;
  bpa_pkg::meta_t meta_wdata, meta_rd;
  logic [AW-1:0]  next_wdata, prev_wdata, next_rd, prev_rd;

  // List head write port.
  logic           lf_we;
  logic [LVW-1:0] lf_idx;
  logic [AW-1:0]  lf_wdata;

  bpa_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rd)
  );
  bpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rd)
  );
  bpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_rd)
  );

  // Address arithmetic for buddies, halves and split blocks.
  logic [CW-1:0]  p_c, b_c, bs, bud, half, split_b;
  logic [LVW-1:0] lvl_dn;
  logic           right;
  logic [AW-1:0]  lf_cur;

  assign p_c     = CW'(p);
  assign b_c     = CW'(b);
  assign bs      = CW'(1) << lvl;
  assign bud     = p_c ^ bs;
  assign right   = ((p_c & bs) == '0);
  assign half    = b_c + (bs >> 1);
  assign lvl_dn  = lvl - LVW'(1);
  assign split_b = p_c + (CW'(1) << lvl_dn);
  assign lf_cur  = list_first[lvl];

  // Initial carving of the run, one page per cycle.
  logic [CW-1:0]  i_c, left;
  logic           init_start, init_top;
  logic [LVW-1:0] init_ord;
  logic [AW-1:0]  init_nx, init_pv;

  assign i_c        = CW'(init_i);
  assign left       = NUM_C - i_c;
  assign init_start = (i_c == next_start);
  assign init_top   = (left >= TOP_SIZE);
  assign init_ord   = init_top ? TOP_LVL : msb_of(left);
  assign init_nx    = (i_c >= TOP_SIZE) ? AW'(i_c - TOP_SIZE) : NIL;
  assign init_pv    = (i_c + (TOP_SIZE << 1) <= NUM_C) ? AW'(i_c + TOP_SIZE) : NIL;

  // Status toward the controller.
  always_comb begin
    stat.init_last  = (init_i == AW'(NUM_PAGES - 1));
    stat.ord_big    = (req_q.order > bpa_pkg::ORD_W'(TOP_ORDER));
    stat.is_free    = (req_q.op == bpa_pkg::OP_FREE);
    stat.pg_oob     = (32'(req_q.page_index) >= 32'(NUM_PAGES));
    stat.found      = (lf_cur != NIL);
    stat.lvl_top    = (lvl == TOP_LVL);
    stat.lvl_eq_ord = (bpa_pkg::ORD_W'(lvl) == req_q.order);
    stat.pg_ok      = meta_rd.head && meta_rd.used && (meta_rd.ord == req_q.order);
    stat.run_end    = right && (bud + bs > NUM_C);
    stat.bud_ok     = meta_rd.head && !meta_rd.used &&
                      (meta_rd.ord == bpa_pkg::ORD_W'(lvl));
    stat.lvl_zero   = (lvl == '0);
    stat.half_head  = meta_rd.head;
  end

  // Memory and list head accesses per command.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = '0;
    meta_wdata = '0;
    meta_raddr = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = NIL;
    next_raddr = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = NIL;
    prev_raddr = '0;
    lf_we      = 1'b0;
    lf_idx     = lvl;
    lf_wdata   = NIL;
    unique case (cmd.op)
      bpa_pkg::DP_INIT: begin
        meta_we    = 1'b1;
        meta_waddr = IW'(init_i);
        meta_wdata = init_start ?
                     bpa_pkg::mk_meta(1'b1, 1'b0, bpa_pkg::ORD_W'(init_ord)) : '0;
        next_we    = 1'b1;
        next_waddr = IW'(init_i);
        next_wdata = (init_start && init_top) ? init_nx : NIL;
        prev_we    = 1'b1;
        prev_waddr = IW'(init_i);
        prev_wdata = (init_start && init_top) ? init_pv : NIL;
        lf_we      = init_start;
        lf_idx     = init_ord;
        lf_wdata   = init_i;
      end
      bpa_pkg::DP_RD_PG: begin
        meta_raddr = IW'(req_q.page_index);
      end
      bpa_pkg::DP_SCAN: begin
        next_raddr = IW'(lf_cur);
      end
      bpa_pkg::DP_UNLINK_HEAD: begin
        lf_we      = 1'b1;
        lf_wdata   = next_rd;
        prev_we    = (next_rd != NIL);
        prev_waddr = IW'(next_rd);
      end
      bpa_pkg::DP_SPLIT: begin
        meta_we    = 1'b1;
        meta_waddr = IW'(split_b);
        meta_wdata = bpa_pkg::mk_meta(1'b1, 1'b0, bpa_pkg::ORD_W'(lvl_dn));
        next_we    = 1'b1;
        next_waddr = IW'(split_b);
        prev_we    = 1'b1;
        prev_waddr = IW'(split_b);
        lf_we      = 1'b1;
        lf_idx     = lvl_dn;
        lf_wdata   = AW'(split_b);
      end
      bpa_pkg::DP_ALLOC_FIN: begin
        meta_we    = 1'b1;
        meta_waddr = IW'(p);
        meta_wdata = bpa_pkg::mk_meta(1'b1, 1'b1, req_q.order);
      end
      bpa_pkg::DP_BUD: begin
        meta_raddr = IW'(bud);
      end
      bpa_pkg::DP_RD_HALF: begin
        meta_raddr = IW'(half);
      end
      bpa_pkg::DP_RD_LINKS: begin
        next_raddr = IW'(b);
        prev_raddr = IW'(b);
      end
      bpa_pkg::DP_UNLINK_B: begin
        next_we    = (prev_rd != NIL);
        next_waddr = IW'(prev_rd);
        next_wdata = next_rd;
        lf_we      = (prev_rd == NIL);
        lf_wdata   = next_rd;
        prev_we    = (next_rd != NIL);
        prev_waddr = IW'(next_rd);
        prev_wdata = prev_rd;
        // The upper half of the merged pair stops being a block start.
        meta_we    = 1'b1;
        meta_waddr = (b < p) ? IW'(p) : IW'(b);
        meta_wdata = '0;
      end
      bpa_pkg::DP_PUSH1: begin
        meta_we    = 1'b1;
        meta_waddr = IW'(p);
        meta_wdata = bpa_pkg::mk_meta(1'b1, 1'b0, bpa_pkg::ORD_W'(lvl));
        next_we    = 1'b1;
        next_waddr = IW'(p);
        next_wdata = lf_cur;
        prev_we    = 1'b1;
        prev_waddr = IW'(p);
        lf_we      = 1'b1;
        lf_wdata   = p;
      end
      bpa_pkg::DP_PUSH2: begin
        prev_we    = (fl != NIL);
        prev_waddr = IW'(fl);
        prev_wdata = p;
      end
      default: begin
      end
    endcase
  end

  // Control registers: carving counters, list heads, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_i     <= '0;
      next_start <= '0;
      done       <= 1'b0;
      for (int k = 0; k <= TOP_ORDER; k++) begin
        list_first[k] <= NIL;
      end
    end else begin
      done <= cmd.respond;
      if (cmd.op == bpa_pkg::DP_INIT) begin
        init_i <= init_i + AW'(1);
        if (init_start) next_start <= next_start + (CW'(1) << init_ord);
      end
      if (lf_we) list_first[lf_idx] <= lf_wdata;
    end
  end

  // Working registers and result item.
  always_ff @(posedge clk) begin
    case (cmd.op)
      bpa_pkg::DP_LOAD: begin
        req_q <= req;
        p     <= AW'(req.page_index);
        lvl   <= LVW'(req.order);
      end
      bpa_pkg::DP_SCAN: begin
        if (stat.found) begin
          p <= lf_cur;
        end else if (!stat.lvl_top) begin
          lvl <= lvl + LVW'(1);
        end
      end
      bpa_pkg::DP_SPLIT: lvl <= lvl_dn;
      bpa_pkg::DP_BUD:   b   <= AW'(bud);
      bpa_pkg::DP_UNLINK_B: begin
        if (b < p) p <= b;
        lvl <= lvl + LVW'(1);
      end
      bpa_pkg::DP_PUSH1: fl <= lf_cur;
      default: begin
      end
    endcase
    if (cmd.respond) begin
      rsp.status         <= cmd.code;
      rsp.page_index_res <= (cmd.code == bpa_pkg::ST_OK && req_q.op == bpa_pkg::OP_ALLOC) ?
                            bpa_pkg::PAGE_W'(p) : '0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/buddy_page_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_core: buddy allocator over a fixed run of pages
//
//   channel   handshake           payload
//   request   start / busy        req  (op, order, page_index)
//   result    done (one cycle)    rsp  (page_index_res, status)
//
// After reset the block carves the run into free blocks, one page per
// cycle, and stays busy until the run is carved. One item is in work at a
// time. An allocate searches the free lists upward from the requested order
// and then splits down to it; a free checks the page and then merges with
// free buddies level by level until a buddy check stops the merge. Each step
// waits on the registered reads of the metadata and link memories.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core #(
  parameter int NUM_PAGES = 1024,
  parameter int TOP_ORDER = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output      logic          busy,
  input  wire bpa_pkg::req_t req,
  output      logic          done,
  output      bpa_pkg::rsp_t rsp
);
  bpa_pkg::dp_cmd_t  cmd;
  bpa_pkg::dp_stat_t stat;

  // Sequencer.
  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  // Memories and working registers.
  bpa_dpath #(.NUM_PAGES(NUM_PAGES), .TOP_ORDER(TOP_ORDER)) u_dpath (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .stat(stat), .rsp(rsp), .done(done)
  );

`ifndef ASSERT_OFF
  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result appears only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Error results carry page zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != bpa_pkg::ST_OK) |-> (rsp.page_index_res == '0))
    else $error("error result with nonzero page");
`endif
endmodule
`default_nettype wire
